@@ design/liu_pkg.sv @@
// Shared types, constants and control structs for the linear interpolation upsampler.
// This file has no dependencies. Every other design file uses it by scoped names.
package liu_pkg;

  // Sample and phase widths.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_W     = FRAC_BITS + 1;

  // Phase constants in Q1.FRAC_BITS.
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_MIN  = PHASE_ONE >> 5;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

  // Payload words.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          run_last;
  } out_word_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_INTERP = 2'd1,
    ST_TAIL   = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Latch the incoming word and the effective step.
    logic emit;       // Write one output word and advance the phase.
    logic sel_tail;   // The emitted word repeats the current sample.
    logic close_ivl;  // The current sample becomes the previous one.
    logic end_trace;  // Clear phase and previous flag after the final sample.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;  // A sample of the current trace is held.
    logic wrap;       // The advanced phase reaches one.
    logic last;       // The held sample ends its trace.
    logic out_free;   // The output register can take a word this cycle.
  } dp_stat_t;

endpackage

@@ design/liu_ctrl.sv @@
// Controller state machine for the linear interpolation upsampler.
// Depends on liu_pkg for the state type and the command and status structs.
module liu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_eos,
  output logic              in_stall,
  input  liu_pkg::dp_stat_t stat,
  output liu_pkg::dp_cmd_t  cmd
);

  liu_pkg::state_t state_r;
  liu_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= liu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      liu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.have_prev) begin
            state_nxt = liu_pkg::ST_INTERP;
          end else if (in_eos) begin
            state_nxt = liu_pkg::ST_TAIL;
          end else begin
            cmd.close_ivl = 1'b1;
          end
        end
      end
      liu_pkg::ST_INTERP: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.wrap) begin
            if (stat.last) begin
              state_nxt = liu_pkg::ST_TAIL;
            end else begin
              cmd.close_ivl = 1'b1;
              state_nxt     = liu_pkg::ST_IDLE;
            end
          end
        end
      end
      liu_pkg::ST_TAIL: begin
        cmd.sel_tail = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.wrap) begin
            cmd.end_trace = 1'b1;
            state_nxt     = liu_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = liu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/liu_datapath.sv @@
// Datapath of the linear interpolation upsampler: sample and phase registers,
// the interpolation multiplier and the output register. Depends on liu_pkg.
module liu_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  liu_pkg::in_word_t             in_data,
  input  logic [liu_pkg::PHASE_W-1:0]   phase_step,
  input  liu_pkg::dp_cmd_t              cmd,
  output liu_pkg::dp_stat_t             stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output liu_pkg::out_word_t            out_data
);

  localparam int DIFF_W = liu_pkg::SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + liu_pkg::PHASE_W + 1;

  logic signed [liu_pkg::SAMPLE_BITS-1:0] prev_r;
  logic signed [liu_pkg::SAMPLE_BITS-1:0] cur_r;
  logic                                   last_r;
  logic [liu_pkg::PHASE_W-1:0]            step_r;
  logic [liu_pkg::PHASE_W-1:0]            ph_r;
  logic                                   have_prev_r;
  logic                                   out_valid_r;
  liu_pkg::out_word_t                     out_word_r;

  logic [liu_pkg::PHASE_W-1:0]            step_eff;
  logic [liu_pkg::PHASE_W:0]              ph_sum;
  logic                                   wrap;
  logic signed [DIFF_W-1:0]               diff;
  logic signed [PROD_W-1:0]               prod;
  logic signed [PROD_W-1:0]               prod_sh;
  logic signed [liu_pkg::SAMPLE_BITS-1:0] interp;
  liu_pkg::out_word_t                     word_nxt;

  // Clamp the programmed step to the supported range.
  always_comb begin
    step_eff = phase_step;
    if (phase_step < liu_pkg::STEP_MIN) begin
      step_eff = liu_pkg::STEP_MIN;
    end else if (phase_step > liu_pkg::PHASE_ONE) begin
      step_eff = liu_pkg::PHASE_ONE;
    end
  end

  // Phase advance; the interval closes when the phase reaches one.
  assign ph_sum = {1'b0, ph_r} + {1'b0, step_r};
  assign wrap   = ph_sum >= {1'b0, liu_pkg::PHASE_ONE};

  // Interpolation: prev + floor((cur - prev) * phase / one).
  assign diff    = DIFF_W'(cur_r) - DIFF_W'(prev_r);
  assign prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, ph_r}));
  assign prod_sh = prod >>> liu_pkg::FRAC_BITS;
  assign interp  = prev_r + liu_pkg::SAMPLE_BITS'(prod_sh);

  // Select the outgoing word and mark the last one of this input.
  always_comb begin
    if (cmd.sel_tail) begin
      word_nxt.value    = cur_r;
      word_nxt.run_last = wrap;
    end else begin
      word_nxt.value    = interp;
      word_nxt.run_last = wrap && !last_r;
    end
  end

  // Input word and step capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_data.sample;
      last_r <= in_data.end_of_stream;
      step_r <= step_eff;
    end
  end

  // Previous sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.close_ivl || cmd.end_trace) begin
      prev_r <= cmd.load ? in_data.sample : cur_r;
    end
  end

  // Phase and trace flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (cmd.end_trace) begin
        ph_r <= '0;
      end else if (cmd.emit) begin
        ph_r <= wrap ? liu_pkg::PHASE_W'(ph_sum - {1'b0, liu_pkg::PHASE_ONE})
                     : liu_pkg::PHASE_W'(ph_sum);
      end
      if (cmd.end_trace) begin
        have_prev_r <= 1'b0;
      end else if (cmd.close_ivl) begin
        have_prev_r <= 1'b1;
      end
    end
  end

  // Output register; it holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= word_nxt;
    end
  end

  assign stat.have_prev = have_prev_r;
  assign stat.wrap      = wrap;
  assign stat.last      = last_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

@@ design/linear_interp_upsampler.sv @@
// Linear interpolation upsampler, top level: configuration register, controller, datapath.
// An input is taken in ST_IDLE; ST_INTERP or ST_TAIL emit its words into the output register.
// Throughput: an input that closes an interval gives N outputs (at most 32, or 64 on a final
// sample); one output word leaves per cycle from the one interpolation unit while not stalled.
// Reset: synchronous, active low; step returns to one, phase and previous sample to zero.
// Depends on liu_pkg, liu_ctrl and liu_datapath.
module linear_interp_upsampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  liu_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output liu_pkg::out_word_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [liu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [liu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [liu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [liu_pkg::PHASE_W-1:0] phase_step_r;
  liu_pkg::reg_idx_t           reg_idx;
  logic                        cfg_wr;
  liu_pkg::dp_cmd_t            cmd;
  liu_pkg::dp_stat_t           stat;

  // Register decode: one word per register.
  assign reg_idx = liu_pkg::reg_idx_t'(paddr[liu_pkg::CFG_ADDR_W-1]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  // Step register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= liu_pkg::PHASE_ONE;
    end else if (cfg_wr && (reg_idx == liu_pkg::REG_PHASE_STEP)) begin
      phase_step_r <= pwdata[liu_pkg::PHASE_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      liu_pkg::REG_PHASE_STEP: prdata = liu_pkg::CFG_DATA_W'(phase_step_r);
      default:                 prdata = '0;
    endcase
  end

  liu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eos   (in_data.end_of_stream),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  liu_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .phase_step (phase_step_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for linear_interp_upsampler: directed and random sample traces.
// It predicts every interpolated output word in a small scoreboard class and checks each one.
// Depends on liu_pkg and the linear_interp_upsampler top level.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int TAIL_CYCLES   = 12;
  localparam int SEG_ITEMS     = 55;
  localparam int NUM_SEGS      = 6;
  localparam logic [liu_pkg::CFG_ADDR_W-1:0] ADDR_STEP = {liu_pkg::REG_PHASE_STEP, 2'b00};
  localparam logic [liu_pkg::CFG_ADDR_W-1:0] ADDR_NONE = {liu_pkg::REG_NONE, 2'b00};

  // Predicts the interpolated words and holds them until the block delivers them.
  class interp_checker;
    logic [liu_pkg::PHASE_W-1:0]            step_reg;
    logic signed [liu_pkg::SAMPLE_BITS-1:0] prev_sample;
    int unsigned                            phase;
    bit                                     have_prev;
    liu_pkg::out_word_t                     expected_words[$];
    int                                     errors;
    int                                     taken;
    int                                     checked;

    function new();
      step_reg    = liu_pkg::PHASE_ONE;
      prev_sample = '0;
      phase       = 0;
      have_prev   = 1'b0;
      errors      = 0;
      taken       = 0;
      checked     = 0;
    endfunction

    // Only the step register holds state; other addresses are ignored.
    function void write_reg(logic [liu_pkg::CFG_ADDR_W-1:0] addr,
                            logic [liu_pkg::CFG_DATA_W-1:0] data);
      if (addr == ADDR_STEP) step_reg = data[liu_pkg::PHASE_W-1:0];
    endfunction

    function void push_value(longint v);
      liu_pkg::out_word_t e;
      e.value    = v[liu_pkg::SAMPLE_BITS-1:0];
      e.run_last = 1'b0;
      expected_words.push_back(e);
    endfunction

    // Closes the interval to the new sample and, on a final sample, fills the tail.
    function void take_sample(liu_pkg::in_word_t w);
      int unsigned eff;
      int unsigned ph;
      int unsigned one;
      int          n;
      longint      cur;
      longint      prv;
      longint      diff;
      one = liu_pkg::PHASE_ONE;
      if (step_reg < liu_pkg::STEP_MIN) eff = liu_pkg::STEP_MIN;
      else if (step_reg > liu_pkg::PHASE_ONE) eff = liu_pkg::PHASE_ONE;
      else eff = step_reg;
      ph  = phase;
      n   = 0;
      cur = $signed(w.sample);
      prv = prev_sample;
      if (have_prev) begin
        diff = cur - prv;
        while (ph < one) begin
          // Arithmetic shift truncates toward negative infinity.
          push_value(prv + ((diff * longint'(ph)) >>> liu_pkg::FRAC_BITS));
          n++;
          ph += eff;
        end
        ph -= one;
      end
      if (w.end_of_stream) begin
        while (ph < one) begin
          push_value(cur);
          n++;
          ph += eff;
        end
        phase     = 0;
        have_prev = 1'b0;
      end else begin
        phase     = ph;
        have_prev = 1'b1;
      end
      prev_sample = w.sample;
      if (n > 0) expected_words[expected_words.size()-1].run_last = 1'b1;
      taken++;
    endfunction

    function void check_word(liu_pkg::out_word_t got);
      liu_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: value %0d run_last %0b", got.value, got.run_last);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      checked++;
      if (got.value !== exp_w.value) begin
        $error("value: expected %0d, got %0d", exp_w.value, got.value);
        errors++;
      end
      if (got.run_last !== exp_w.run_last) begin
        $error("run_last: expected %0b, got %0b", exp_w.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  liu_pkg::in_word_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  liu_pkg::out_word_t             out_data;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [liu_pkg::CFG_ADDR_W-1:0] paddr     = '0;
  logic [liu_pkg::CFG_DATA_W-1:0] pwdata    = '0;
  logic [liu_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  interp_checker sb = new();
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            cycles        = 0;
  int            reg_writes    = 0;

  linear_interp_upsampler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** linear_interp_upsampler: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watch both channels; values read here are the ones before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_word(out_data);
      if (in_valid && !in_stall) sb.take_sample(in_data);
    end
  end

  // Offers one word and returns at the edge that accepts it.
  task automatic send_word(input logic [liu_pkg::SAMPLE_BITS-1:0] sample, input logic eos);
    liu_pkg::in_word_t w;
    w.sample        = sample;
    w.end_of_stream = eos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [liu_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [liu_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr, data);
    reg_writes++;
  endtask

  // Drops valid, then waits until every predicted word has come out and the block settles.
  // The first edge lets the monitor note a word accepted at the edge the sender returned on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [liu_pkg::SAMPLE_BITS-1:0] pick_sample(
    logic [liu_pkg::SAMPLE_BITS-1:0] last);
    logic [liu_pkg::SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 3))
      0: s = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: s = last + liu_pkg::SAMPLE_BITS'($urandom_range(0, 64)) - 16'd32;
      default: s = liu_pkg::SAMPLE_BITS'($urandom);
    endcase
    return s;
  endfunction

  // Mostly complete traces ending on a final sample, with some loose words mixed in.
  task automatic run_random(input int count);
    int                              sent;
    int                              len;
    logic [liu_pkg::SAMPLE_BITS-1:0] s;
    sent = 0;
    s    = '0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          s = pick_sample(s);
          send_word(s, i == len - 1);
          sent++;
        end
      end else begin
        s = liu_pkg::SAMPLE_BITS'($urandom);
        send_word(s, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [liu_pkg::CFG_DATA_W-1:0] step_val;
    send_idle_pct = 36;
    recv_idle_pct = 51;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass-through step from reset: first sample, full-scale swings, final samples.
    send_word(16'd0, 1'b0);
    send_word(16'h7fff, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'd5, 1'b1);
    wait_idle();

    // Finest step: negative products round down, final interval doubles the count.
    cfg_write(ADDR_STEP, 32'd2048);
    send_word(16'h8000, 1'b0);
    send_word(16'h7fff, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'd1, 1'b1);
    send_word(16'h7fff, 1'b1);
    wait_idle();

    // Step below the floor is clamped up.
    cfg_write(ADDR_STEP, 32'd0);
    send_word(16'd100, 1'b0);
    send_word(-16'sd100, 1'b1);
    wait_idle();

    // Step above one is clamped down; upper data bits are dropped.
    cfg_write(ADDR_STEP, 32'hffff_ffff);
    send_word(16'd1234, 1'b0);
    send_word(-16'sd1234, 1'b0);
    send_word(16'd7, 1'b1);
    wait_idle();

    // Step that does not divide one, so the phase drifts between intervals.
    cfg_write(ADDR_STEP, 32'd3000);
    send_word(16'h8000, 1'b0);
    send_word(16'h7fff, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(-16'sd5, 1'b1);
    wait_idle();

    // A write to the unused address must leave the step alone.
    cfg_write(ADDR_NONE, $urandom);
    send_word(16'd10, 1'b0);
    send_word(16'd20, 1'b1);
    wait_idle();

    // Random segments, one step setting each, idle profile changing every two.
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: step_val = 32'd2048;
        1: step_val = 32'd65536;
        2: step_val = $urandom;
        3: step_val = $urandom_range(2048, 65536);
        4: step_val = $urandom_range(0, 2047);
        default: step_val = $urandom_range(65537, 131071);
      endcase
      cfg_write(ADDR_STEP, step_val);
      run_random(SEG_ITEMS);
      wait_idle();
    end

    if (sb.expected_words.size() != 0) begin
      $error("%0d predicted output words never arrived", sb.expected_words.size());
      sb.errors++;
    end
    $display("Run covered %0d input words, %0d checked output words, %0d register writes.",
             sb.taken, sb.checked, reg_writes);
    $display("Steps ranged from below the clamp floor to above one, under both idle orders.");
    if (sb.errors == 0) begin
      $display("** linear_interp_upsampler: PASSED **");
    end else begin
      $display("** linear_interp_upsampler: FAILED **");
    end
    $finish;
  end

endmodule
